@@ rtl/ljd_pkg.sv @@
// Package for the least-loaded job dispatcher.
// Holds widths, reset values, register codes and the structs shared between the modules.
`timescale 1ns / 1ps
package ljd_pkg;

  localparam int NPROC   = 8;
  localparam int PROC_W  = $clog2(NPROC);
  localparam int NCNT_W  = $clog2(NPROC + 1);
  localparam int TIME_W  = 16;
  localparam int FIN_W   = 32;
  localparam int ACT_W   = 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [ACT_W-1:0]  ACTIVE_RST = 4'd2;
  localparam logic              POLICY_RST = 1'b1;
  localparam logic [TIME_W-1:0] CNT_MAX    = '1;
  localparam logic [FIN_W-1:0]  FIN_MAX    = '1;

  typedef enum logic {
    REG_ACTIVE_PROCS = 1'b0,
    REG_POLICY_MODE  = 1'b1
  } reg_idx_e;

  typedef enum logic {
    POLICY_RR = 1'b0,
    POLICY_LL = 1'b1
  } policy_e;

  typedef struct packed {
    logic [ACT_W-1:0] active_procs;
    logic             policy_mode;
  } cfg_t;

  typedef struct packed {
    logic              rd_en;
    logic [PROC_W-1:0] rd_addr;
    logic              wr_en;
    logic [PROC_W-1:0] wr_addr;
    logic [FIN_W-1:0]  wr_data;
    logic              clr;
  } mem_req_t;

  function automatic logic [NCNT_W-1:0] procs_in_use(input logic [ACT_W-1:0] act);
    logic [NCNT_W-1:0] n;
    if (act == '0) begin
      n = NCNT_W'(1);
    end else if (int'(act) > NPROC) begin
      n = NCNT_W'(NPROC);
    end else begin
      n = NCNT_W'(act);
    end
    return n;
  endfunction

endpackage

@@ rtl/ljd_cfg.sv @@
// APB-style configuration registers of the job dispatcher.
// Depends on ljd_pkg for widths, register codes and the configuration struct.
`timescale 1ns / 1ps
module ljd_cfg import ljd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  logic [ACT_W-1:0] active_q, active_d;
  logic             policy_q, policy_d;
  logic             wr_en;
  reg_idx_e         idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[2]);

  always_comb begin
    active_d = active_q;
    policy_d = policy_q;
    prdata   = '0;
    unique case (idx)
      REG_ACTIVE_PROCS: begin
        prdata = PDATA_W'(active_q);
        if (wr_en) begin
          active_d = pwdata[ACT_W-1:0];
        end
      end
      REG_POLICY_MODE: begin
        prdata = PDATA_W'(policy_q);
        if (wr_en) begin
          policy_d = pwdata[0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RST;
      policy_q <= POLICY_RST;
    end else begin
      active_q <= active_d;
      policy_q <= policy_d;
    end
  end

  assign cfg_o.active_procs = active_q;
  assign cfg_o.policy_mode  = policy_q;

endmodule

@@ rtl/ljd_fin_mem.sv @@
// Finish-time memory: one write port and one registered read port.
// Valid bits make unwritten entries read as zero; depends on ljd_pkg.
`timescale 1ns / 1ps
module ljd_fin_mem import ljd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mem_req_t         req_i,
  output logic [FIN_W-1:0] rd_data_o
);

  logic [FIN_W-1:0] fin_mem_q [NPROC];
  logic [NPROC-1:0] valid_q;
  logic [FIN_W-1:0] ram_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      fin_mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      ram_q <= fin_mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? ram_q : '0;

endmodule

@@ rtl/ljd_core.sv @@
// Dispatch sequencer: picks a finish-time entry (least-loaded scan or
// round-robin), updates it and builds each result. Depends on ljd_pkg, ljd_fin_mem.
`timescale 1ns / 1ps
module ljd_core import ljd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [TIME_W-1:0] arrival_i,
  input  logic [TIME_W-1:0] ptime_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        out_proc_o,
  output logic [FIN_W-1:0]  out_finish_o,
  output logic              out_last_o,
  output logic [FIN_W-1:0]  out_turn_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_UPD  = 5'b00100,
    ST_MAX  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [TIME_W-1:0] cnt_q, cnt_d;
  logic [TIME_W-1:0] first_q, first_d;
  logic [PROC_W-1:0] rr_q, rr_d;
  logic              out_valid_q, out_valid_d;

  logic [TIME_W-1:0] arr_q, arr_d;
  logic [TIME_W-1:0] pt_q, pt_d;
  logic              last_q, last_d;
  logic [PROC_W-1:0] pick_q, pick_d;
  logic [PROC_W-1:0] cur_q, cur_d;
  logic [FIN_W-1:0]  min_q, min_d;
  logic [FIN_W-1:0]  max_q, max_d;
  logic [FIN_W-1:0]  newf_q, newf_d;
  logic              from_mem_q, from_mem_d;
  logic [2:0]        out_proc_q, out_proc_d;
  logic [FIN_W-1:0]  out_fin_q, out_fin_d;
  logic              out_last_q, out_last_d;
  logic [FIN_W-1:0]  out_turn_q, out_turn_d;

  mem_req_t          mem_req;
  logic [FIN_W-1:0]  rd_data;
  logic [NCNT_W-1:0] n;
  logic [NCNT_W-1:0] cur_nxt;
  logic [PROC_W-1:0] rr_eff;
  logic [NCNT_W-1:0] rr_inc;
  logic [FIN_W-1:0]  base;
  logic [FIN_W-1:0]  raised;
  logic [FIN_W:0]    fsum;
  logic [FIN_W-1:0]  newf;
  logic [FIN_W-1:0]  mval;
  logic [FIN_W:0]    tsum;
  logic [FIN_W:0]    tdiff;
  logic [FIN_W-1:0]  turn;

  ljd_fin_mem u_fin_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  assign n       = procs_in_use(cfg_i.active_procs);
  assign cur_nxt = NCNT_W'(cur_q) + NCNT_W'(1);
  assign rr_eff  = (NCNT_W'(rr_q) >= n) ? '0 : rr_q;
  assign rr_inc  = NCNT_W'(rr_eff) + NCNT_W'(1);

  assign base   = from_mem_q ? rd_data : min_q;
  assign raised = (base < FIN_W'(arr_q)) ? FIN_W'(arr_q) : base;
  assign fsum   = {1'b0, raised} + (FIN_W + 1)'(pt_q);
  assign newf   = fsum[FIN_W] ? FIN_MAX : fsum[FIN_W-1:0];
  assign mval   = (cur_q == pick_q) ? newf_q : rd_data;

  assign tsum  = (FIN_W + 1)'(cnt_q) + {1'b0, max_q};
  assign tdiff = tsum - (FIN_W + 1)'(first_q);
  always_comb begin
    if (tsum > (FIN_W + 1)'(first_q)) begin
      turn = tdiff[FIN_W] ? FIN_MAX : tdiff[FIN_W-1:0];
    end else begin
      turn = '0;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    first_d     = first_q;
    rr_d        = rr_q;
    out_valid_d = out_valid_q;
    arr_d       = arr_q;
    pt_d        = pt_q;
    last_d      = last_q;
    pick_d      = pick_q;
    cur_d       = cur_q;
    min_d       = min_q;
    max_d       = max_q;
    newf_d      = newf_q;
    from_mem_d  = from_mem_q;
    out_proc_d  = out_proc_q;
    out_fin_d   = out_fin_q;
    out_last_d  = out_last_q;
    out_turn_d  = out_turn_q;
    mem_req     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          arr_d  = arrival_i;
          pt_d   = ptime_i;
          last_d = last_i;
          if (cnt_q == '0) begin
            first_d = arrival_i;
          end
          if (cnt_q != CNT_MAX) begin
            cnt_d = cnt_q + TIME_W'(1);
          end
          mem_req.rd_en = 1'b1;
          if (policy_e'(cfg_i.policy_mode) == POLICY_LL) begin
            mem_req.rd_addr = '0;
            cur_d           = '0;
            from_mem_d      = 1'b0;
            state_d         = ST_SCAN;
          end else begin
            mem_req.rd_addr = rr_eff;
            pick_d          = rr_eff;
            rr_d            = (rr_inc >= n) ? '0 : PROC_W'(rr_inc);
            from_mem_d      = 1'b1;
            state_d         = ST_UPD;
          end
        end
      end
      ST_SCAN: begin
        if ((cur_q == '0) || (rd_data < min_q)) begin
          min_d  = rd_data;
          pick_d = cur_q;
        end
        if (cur_nxt < n) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = PROC_W'(cur_nxt);
          cur_d           = PROC_W'(cur_nxt);
        end else begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pick_q;
        mem_req.wr_data = newf;
        newf_d          = newf;
        if (last_q) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = '0;
          cur_d           = '0;
          max_d           = '0;
          state_d         = ST_MAX;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_MAX: begin
        if (mval > max_q) begin
          max_d = mval;
        end
        if (cur_nxt < n) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = PROC_W'(cur_nxt);
          cur_d           = PROC_W'(cur_nxt);
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_proc_d  = 3'(pick_q);
          out_fin_d   = newf_q;
          out_last_d  = last_q;
          out_turn_d  = last_q ? turn : '0;
          if (last_q) begin
            cnt_d       = '0;
            first_d     = '0;
            rr_d        = '0;
            mem_req.clr = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      first_q     <= '0;
      rr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      first_q     <= first_d;
      rr_q        <= rr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    arr_q      <= arr_d;
    pt_q       <= pt_d;
    last_q     <= last_d;
    pick_q     <= pick_d;
    cur_q      <= cur_d;
    min_q      <= min_d;
    max_q      <= max_d;
    newf_q     <= newf_d;
    from_mem_q <= from_mem_d;
    out_proc_q <= out_proc_d;
    out_fin_q  <= out_fin_d;
    out_last_q <= out_last_d;
    out_turn_q <= out_turn_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_proc_o   = out_proc_q;
  assign out_finish_o = out_fin_q;
  assign out_last_o   = out_last_q;
  assign out_turn_o   = out_turn_q;

endmodule

@@ rtl/least_loaded_job_dispatcher_top.sv @@
// Top level of the least-loaded job dispatcher.
// Depends on ljd_pkg, ljd_cfg and ljd_core (which holds ljd_fin_mem).
//
//   Channel   Direction  Handshake                  Payload
//   s_axis    in         s_axis_tvalid/tready       tdata, tlast (job request)
//   m_axis    out        m_axis_tvalid/tready       tdata, tlast (dispatch result)
//   apb       in         psel/penable/pready        paddr, pwdata, prdata
//
// The finish-time memory has a single read port, which the minimum scan (least-loaded
// mode) and the final maximum scan of a list walk one entry per cycle over the processors
// in use. Jobs are taken only in the idle state, so one job is handled at a time.
// Reset clears the finish times at once through the memory valid bits; the end of a list
// does the same. A stalled output holds its result; the next result waits, and no new
// job is taken meanwhile.
`timescale 1ns / 1ps
module least_loaded_job_dispatcher_top import ljd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,  // arrival_time[15:0], proc_time[31:16]
  input  logic               s_axis_tlast,  // last_job
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [71:0]        m_axis_tdata,  // assigned_proc, new_finish, total_turnaround
  output logic               m_axis_tlast,  // list_done
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t             cfg;
  logic [2:0]       out_proc;
  logic [FIN_W-1:0] out_finish;
  logic [FIN_W-1:0] out_turn;

  ljd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ljd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .arrival_i    (s_axis_tdata[15:0]),
    .ptime_i      (s_axis_tdata[31:16]),
    .last_i       (s_axis_tlast),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_proc_o   (out_proc),
    .out_finish_o (out_finish),
    .out_last_o   (m_axis_tlast),
    .out_turn_o   (out_turn)
  );

  assign m_axis_tdata = {5'b0, out_turn, out_finish, out_proc};

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for least_loaded_job_dispatcher_top.
// A scoreboard class predicts each dispatch result; tasks drive the job stream and APB.
// Depends on ljd_pkg and the dispatcher RTL.
`timescale 1ns / 1ps
module testbench import ljd_pkg::*; ();

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int ONE_PROC_JOBS = 40;

  typedef struct {
    logic [PROC_W-1:0] proc_id;
    logic [FIN_W-1:0]  finish;
    logic              done;
    logic [FIN_W-1:0]  turnaround;
  } dispatch_t;

  class dispatch_scoreboard;
    logic [FIN_W-1:0]  finish_time[NPROC];
    logic [TIME_W-1:0] job_total;
    logic [TIME_W-1:0] first_arr;
    int                rr_next;
    logic [ACT_W-1:0]  act_cfg;
    policy_e           pol;
    dispatch_t         expected_q[$];
    int                errors;

    function new();
      act_cfg = ACTIVE_RST;
      pol     = policy_e'(POLICY_RST);
      errors  = 0;
      clear_list();
    endfunction

    function void clear_list();
      foreach (finish_time[k]) finish_time[k] = '0;
      job_total = '0;
      first_arr = '0;
      rr_next   = 0;
    endfunction

    function int live_procs();
      if (act_cfg == '0) return 1;
      if (int'(act_cfg) > NPROC) return NPROC;
      return int'(act_cfg);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] val);
      if (idx == REG_ACTIVE_PROCS) begin
        act_cfg = val[ACT_W-1:0];
      end else begin
        pol = policy_e'(val[0]);
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < 20) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_reg(reg_idx_e idx, logic [31:0] rd);
      if (idx == REG_ACTIVE_PROCS) begin
        if (rd[ACT_W-1:0] !== act_cfg)
          report_mismatch($sformatf("active_procs read %0h, expected %0h", rd, act_cfg));
      end else begin
        if (rd[0] !== pol)
          report_mismatch($sformatf("policy_mode read %0h, expected %0h", rd, pol));
      end
    endtask

    function void note_job(logic [TIME_W-1:0] arr, logic [TIME_W-1:0] pt, logic last);
      int          n;
      int          pick;
      logic [32:0] acc;
      logic [FIN_W-1:0] mx;
      dispatch_t   want;
      n    = live_procs();
      pick = 0;
      if (job_total == '0) first_arr = arr;
      if (job_total != CNT_MAX) job_total++;
      if (pol == POLICY_LL) begin
        for (int k = 1; k < n; k++)
          if (finish_time[k] < finish_time[pick]) pick = k;
      end else begin
        if (rr_next >= n) rr_next = 0;
        pick    = rr_next;
        rr_next = (rr_next + 1 >= n) ? 0 : rr_next + 1;
      end
      if (finish_time[pick] < FIN_W'(arr)) finish_time[pick] = FIN_W'(arr);
      acc = 33'(finish_time[pick]) + 33'(pt);
      finish_time[pick] = acc[32] ? FIN_MAX : acc[31:0];
      want.proc_id    = PROC_W'(pick);
      want.finish     = finish_time[pick];
      want.done       = last;
      want.turnaround = '0;
      if (last) begin
        mx = '0;
        for (int k = 0; k < n; k++)
          if (finish_time[k] > mx) mx = finish_time[k];
        acc = 33'(job_total) + 33'(mx);
        if (acc > 33'(first_arr)) begin
          acc = acc - 33'(first_arr);
          want.turnaround = acc[32] ? FIN_MAX : acc[31:0];
        end
        clear_list();
      end
      expected_q.insert(expected_q.size(), want);
    endfunction

    task check_dispatch(dispatch_t got);
      dispatch_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("dispatch result with no job outstanding");
        return;
      end
      want = expected_q.pop_front();
      if (got.proc_id !== want.proc_id)
        report_mismatch($sformatf("processor %0d, expected %0d", got.proc_id, want.proc_id));
      if (got.finish !== want.finish)
        report_mismatch($sformatf("finish %0h, expected %0h", got.finish, want.finish));
      if (got.done !== want.done)
        report_mismatch($sformatf("list_done %0b, expected %0b", got.done, want.done));
      if (got.turnaround !== want.turnaround)
        report_mismatch($sformatf("turnaround %0h, expected %0h",
                                  got.turnaround, want.turnaround));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata;   // arrival_time[15:0], proc_time[31:16]
  logic               s_axis_tlast;   // last_job
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [71:0]        m_axis_tdata;   // assigned_proc[2:0], new_finish[34:3], turnaround[66:35]
  logic               m_axis_tlast;   // list_done
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  dispatch_scoreboard sb;
  dispatch_t          rx_item;
  int                 tx_gap_pct;
  int                 rx_stall_pct;
  int                 stall_left;
  int                 cycle_cnt;

  least_loaded_job_dispatcher_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] rand_active();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, NPROC);
    if (r < 88) return 0;
    return $urandom_range(NPROC + 1, 15);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        rx_item.proc_id    = m_axis_tdata[2:0];
        rx_item.finish     = m_axis_tdata[34:3];
        rx_item.turnaround = m_axis_tdata[66:35];
        rx_item.done       = m_axis_tlast;
        sb.check_dispatch(rx_item);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        m_axis_tready <= 1'b0;
        stall_left = gap_len() - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic apb_xfer(input logic wr, input reg_idx_e idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    rdata = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_reg(input reg_idx_e idx);
    logic [31:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    sb.check_reg(idx, rd);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    logic [31:0] rd;
    apb_xfer(1'b1, idx, val, rd);
    sb.set_reg(idx, val);
    read_reg(idx);
  endtask

  task automatic send_job(input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] pt,
                          input logic last);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pt, arr};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_job(arr, pt, last);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_lists(input int budget);
    int sent;
    int len;
    int mid;
    int r;
    int arr;
    int pt;
    bit rising;
    sent = 0;
    while (sent < budget) begin
      if (sent == 0 || $urandom_range(0, 3) == 0) begin
        drain();
        if ($urandom_range(0, 1)) begin
          write_reg(REG_ACTIVE_PROCS, rand_active());
          write_reg(REG_POLICY_MODE, $urandom_range(0, 1));
        end else begin
          write_reg(REG_POLICY_MODE, $urandom_range(0, 1));
          write_reg(REG_ACTIVE_PROCS, rand_active());
        end
        r = $urandom_range(0, 3);
        tx_gap_pct   = (r == 0) ? 0 : (r == 1) ? 15 : (r == 2) ? 40 : 75;
        r = $urandom_range(0, 3);
        rx_stall_pct = (r == 0) ? 0 : (r == 1) ? 15 : (r == 2) ? 40 : 75;
      end
      r   = $urandom_range(0, 99);
      len = (r < 70) ? $urandom_range(1, 12) : (r < 95) ? $urandom_range(13, 40)
                                                         : $urandom_range(41, 120);
      mid    = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : -1;
      rising = $urandom_range(0, 2) != 0;
      arr    = rising ? $urandom_range(0, 2000) : $urandom_range(0, 65535);
      for (int k = 0; k < len; k++) begin
        if (k == mid) begin
          drain();
          write_reg(REG_ACTIVE_PROCS, rand_active());
        end
        if ($urandom_range(0, 79) == 0) drain();
        if (rising) begin
          arr = arr + $urandom_range(0, 300);
          if (arr > 65535) arr = 65535;
        end else begin
          arr = $urandom_range(0, 65535);
        end
        r  = $urandom_range(0, 99);
        pt = (r < 60) ? $urandom_range(1, 200) : (r < 90) ? $urandom_range(1, 65535)
                                                          : (r < 95) ? 65535 : 0;
        send_job(TIME_W'(arr), TIME_W'(pt), k == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    tx_gap_pct    = 20;
    rx_stall_pct  = 20;
    stall_left    = 0;
    cycle_cnt     = 0;
    sb            = new();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    read_reg(REG_ACTIVE_PROCS);
    read_reg(REG_POLICY_MODE);

    send_job(16'h0000, 16'h0001, 1'b0);
    send_job(16'hFFFF, 16'hFFFF, 1'b0);
    send_job(16'h0000, 16'h0000, 1'b0);
    send_job(16'd100, 16'd5, 1'b1);
    drain();

    write_reg(REG_ACTIVE_PROCS, 0);
    send_job(16'd10, 16'hFFFF, 1'b0);
    send_job(16'hFFFF, 16'h0001, 1'b1);
    drain();

    write_reg(REG_ACTIVE_PROCS, 15);
    write_reg(REG_POLICY_MODE, POLICY_RR);
    for (int k = 0; k < 9; k++) send_job(TIME_W'(3 * k), TIME_W'(k + 1), k == 8);
    drain();

    // Shrinking the processor count mid-list leaves the round-robin pointer out of range.
    write_reg(REG_ACTIVE_PROCS, 4);
    for (int k = 0; k < 3; k++) send_job(TIME_W'(k), 16'd7, 1'b0);
    drain();
    write_reg(REG_ACTIVE_PROCS, 2);
    send_job(16'd50, 16'd3, 1'b1);
    drain();

    // One back-to-back list on a single processor stacks every job on processor zero.
    write_reg(REG_ACTIVE_PROCS, 1);
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    send_job(16'h0000, 16'hFFFF, 1'b0);
    for (int k = 0; k < ONE_PROC_JOBS - 2; k++)
      send_job(TIME_W'($urandom), 16'hFFFF, 1'b0);
    send_job(16'h0001, 16'hFFFF, 1'b1);
    drain();

    random_lists(1340);
    drain();
    repeat (60) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ljd_pkg.sv
rtl/ljd_cfg.sv
rtl/ljd_fin_mem.sv
rtl/ljd_core.sv
rtl/least_loaded_job_dispatcher_top.sv
bench/testbench.sv
